>>> hdl/byte_stream_mix_hash32_assert.svh
// Assertion macros used by the checker file of the byte stream hash block.
`ifndef BYTE_STREAM_MIX_HASH32_ASSERT_SVH
`define BYTE_STREAM_MIX_HASH32_ASSERT_SVH

// Implication checked outside reset.
`define BSMH_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Condition that must hold in the cycle after a reset cycle.
`define BSMH_ASSERT_AFTER_RESET(label, clk, rst, cons) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("assertion failed after reset");

`endif

>>> hdl/bsmh_pkg.sv
// Types, constants and mix functions of the byte stream hash block.
`timescale 1ns / 1ps

package bsmh_pkg;

  localparam logic [31:0] Golden = 32'h9e3779b9;
  localparam logic [3:0] BlockLastPos = 4'd11;
  localparam logic [3:0] WordBPos = 4'd4;
  localparam logic [3:0] LaneCPos = 4'd8;
  localparam logic [1:0] MixLastStage = 2'd2;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);
  localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } words_t;

  typedef struct packed {
    logic [31:0] add_a;
    logic [31:0] add_b;
    logic [31:0] add_c;
    logic [31:0] len;
    logic [31:0] seed;
    logic        first;
    logic        two;
    logic        fin;
  } cmd_t;

  function automatic words_t mix_rows(words_t w, int unsigned sa, int unsigned sb,
                                      int unsigned sc);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    words_t r;
    a = w.a;
    b = w.b;
    c = w.c;
    a = (a - b - c) ^ (c >> sa);
    b = (b - c - a) ^ (a << sb);
    c = (c - a - b) ^ (b >> sc);
    r.a = a;
    r.b = b;
    r.c = c;
    return r;
  endfunction

  function automatic words_t mix_stage(words_t w, logic [1:0] stage);
    words_t r;
    case (stage)
      2'd0: r = mix_rows(w, 13, 8, 13);
      2'd1: r = mix_rows(w, 12, 16, 5);
      2'd2: r = mix_rows(w, 3, 10, 15);
      default: r = w;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/bsmh_front.sv
// Front end: accepts key bytes, packs blocks and issues mix commands.
`timescale 1ns / 1ps

module bsmh_front (
  input  logic          clk,
  input  logic          rst,
  input  logic [31:0]   seed,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          in_has,
  input  logic          in_last,
  input  logic          q_full,
  output logic          q_push,
  output bsmh_pkg::cmd_t q_cmd
);
  import bsmh_pkg::*;

  logic [3:0]  pos;
  logic [31:0] acc_a;
  logic [31:0] acc_b;
  logic [31:0] acc_c;
  logic [31:0] len;
  logic        started;
  logic        issued;
  logic [31:0] key_seed;

  logic [31:0] acc_a_next;
  logic [31:0] acc_b_next;
  logic [31:0] acc_c_next;
  logic [31:0] len_next;
  logic [31:0] byte_word;
  logic [31:0] seed_eff;
  logic        blk;
  logic        take;

  assign in_ready = !q_full;
  assign take = in_valid && in_ready && (in_has || in_last);
  assign byte_word = {24'd0, in_byte} << {pos[1:0], 3'b000};
  assign blk = in_has && (pos == BlockLastPos);
  assign q_push = take && (blk || in_last);
  assign seed_eff = started ? key_seed : seed;

  always_comb begin
    acc_a_next = acc_a;
    acc_b_next = acc_b;
    acc_c_next = acc_c;
    len_next = len;
    if (in_has) begin
      len_next = len + 32'd1;
      if (pos < WordBPos) begin
        acc_a_next = acc_a | byte_word;
      end else if (pos < LaneCPos) begin
        acc_b_next = acc_b | byte_word;
      end else begin
        acc_c_next = acc_c | byte_word;
      end
    end
  end

  always_comb begin
    q_cmd.add_a = acc_a_next;
    q_cmd.add_b = acc_b_next;
    q_cmd.add_c = blk ? acc_c_next : len_next + {acc_c_next[23:0], 8'h00};
    q_cmd.len = len_next;
    q_cmd.seed = seed_eff;
    q_cmd.first = !issued;
    q_cmd.two = blk && in_last;
    q_cmd.fin = in_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      acc_a <= '0;
      acc_b <= '0;
      acc_c <= '0;
      len <= '0;
      started <= 1'b0;
      issued <= 1'b0;
      key_seed <= '0;
    end else if (take) begin
      if (in_last) begin
        pos <= '0;
        acc_a <= '0;
        acc_b <= '0;
        acc_c <= '0;
        len <= '0;
        started <= 1'b0;
        issued <= 1'b0;
      end else if (blk) begin
        pos <= '0;
        acc_a <= '0;
        acc_b <= '0;
        acc_c <= '0;
        len <= len_next;
        started <= 1'b1;
        issued <= 1'b1;
        key_seed <= seed_eff;
      end else begin
        pos <= pos + 4'd1;
        acc_a <= acc_a_next;
        acc_b <= acc_b_next;
        acc_c <= acc_c_next;
        len <= len_next;
        started <= 1'b1;
        key_seed <= seed_eff;
      end
    end
  end

endmodule

>>> hdl/bsmh_fifo.sv
// Command queue between the front end and the mix engine.
`timescale 1ns / 1ps

module bsmh_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bsmh_pkg::cmd_t push_cmd,
  input  logic           pop,
  output bsmh_pkg::cmd_t pop_cmd,
  output logic           full,
  output logic           empty
);
  import bsmh_pkg::*;

  cmd_t                 entries [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueueCntW-1:0] count;

  assign full = (count == QueueCntW'(QueueDepth));
  assign empty = (count == '0);
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/bsmh_back.sv
// Mix engine: adds block words, runs the three-stage mix and holds the result.
`timescale 1ns / 1ps

module bsmh_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  bsmh_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [31:0]    m_tdata
);
  import bsmh_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MIX,
    S_LEN,
    S_EMIT
  } state_t;

  state_t      state;
  logic [1:0]  stage;
  words_t      w;
  words_t      base;
  logic        two;
  logic        fin;
  logic [31:0] len;

  assign q_pop = (state == S_IDLE) && !q_empty;

  always_comb begin
    if (q_cmd.first) begin
      base.a = Golden;
      base.b = Golden;
      base.c = q_cmd.seed;
    end else begin
      base = w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      stage <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            w.a <= base.a + q_cmd.add_a;
            w.b <= base.b + q_cmd.add_b;
            w.c <= base.c + q_cmd.add_c;
            two <= q_cmd.two;
            fin <= q_cmd.fin;
            len <= q_cmd.len;
            stage <= '0;
            state <= S_MIX;
          end
        end
        S_MIX: begin
          w <= mix_stage(w, stage);
          if (stage == MixLastStage) begin
            stage <= '0;
            if (two) begin
              two <= 1'b0;
              state <= S_LEN;
            end else if (fin) begin
              state <= S_EMIT;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            stage <= stage + 2'd1;
          end
        end
        S_LEN: begin
          w.c <= w.c + len;
          state <= S_MIX;
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= w.c;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/byte_stream_mix_hash32.sv
// Top level of the streaming 32-bit byte key hash.
//
//   channel  direction  transfer     contents
//   s_*      in         key item     tdata: data_byte; tuser: has_byte; tlast: last
//   m_*      out        hash result  tdata: hash_value
//   cfg_*    in         write        seed register, taken on cfg_we
//
// The front end takes one byte per cycle while the command queue has room.
// Each command passes through the mix engine as an add step and the three mix
// stages, plus a length step and another mix pass when a block ends on the last
// byte, and an output load. Keys of twelve bytes or more stream at one byte per
// cycle while the queue has room; short keys are bounded by the mix engine.
// Reset is synchronous and clears the queue, the key state and the seed.
// The output register holds a result under back pressure while input continues.
`timescale 1ns / 1ps

module byte_stream_mix_hash32 (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] has_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] hash_value
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import bsmh_pkg::*;

  logic [31:0] seed;
  logic        q_full;
  logic        q_empty;
  logic        q_push;
  logic        q_pop;
  cmd_t        push_cmd;
  cmd_t        pop_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg_we) begin
      seed <= cfg_wdata;
    end
  end

  bsmh_front u_front (
    .clk      (clk),
    .rst      (rst),
    .seed     (seed),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_has   (s_tuser),
    .in_last  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  bsmh_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  bsmh_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_cmd    (pop_cmd),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

>>> hdl/bsmh_checker.sv
// Port-level checker of the byte stream hash block and its bind.
`timescale 1ns / 1ps
`include "byte_stream_mix_hash32_assert.svh"

module bsmh_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  `BSMH_ASSERT_IMPLY(a_out_held, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `BSMH_ASSERT_IMPLY(a_out_stable, clk, rst, m_tvalid && !m_tready, $stable(m_tdata))
  `BSMH_ASSERT_AFTER_RESET(a_no_out_after_reset, clk, rst, !m_tvalid)
  `BSMH_ASSERT_AFTER_RESET(a_ready_after_reset, clk, rst, s_tready)

endmodule

bind byte_stream_mix_hash32 bsmh_checker u_bsmh_checker (.*);
